@@ src/mtrs_pkg.sv @@
// Shared types and constants of the Modbus TCP register server.
package mtrs_pkg;

    localparam int REG_DEPTH_DEF = 256;
    localparam int MAX_REGS_DEF  = 64;
    localparam int HDR_LEN       = 13;

    localparam logic [1:0] OP_REQ_BYTE   = 2'd0;
    localparam logic [1:0] OP_LOAD_INPUT = 2'd1;
    localparam logic [1:0] OP_READ_HOLD  = 2'd2;

    localparam logic [7:0] FC_RD_HOLD   = 8'd3;
    localparam logic [7:0] FC_RD_INPUT  = 8'd4;
    localparam logic [7:0] FC_WR_SINGLE = 8'd6;
    localparam logic [7:0] FC_WR_MULTI  = 8'd16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [7:0]  reg_index;
        logic [15:0] reg_value;
    } req_t;

    typedef struct packed {
        logic [15:0] transaction_id;
        logic [15:0] protocol_id;
        logic [15:0] length_field;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [7:0]  byte_count;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic        has_data;
        logic        last;
        logic        error;
    } rsp_t;

    typedef enum logic [2:0] {
        RK_NONE,
        RK_ERROR,
        RK_WRITE1,
        RK_WRITEN,
        RK_READ0,
        RK_READ
    } resp_kind_t;

    typedef enum logic [1:0] {
        EK_APP,
        EK_SINGLE,
        EK_READ
    } emit_kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_APP_RD,
        ST_APP_EMIT,
        ST_SINGLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_READ_ADDR,
        ST_READ_EMIT
    } state_t;

    typedef struct packed {
        logic       clr_step;
        logic       take;
        logic       hold_wr1;
        logic       copy_wr;
        logic       cnt_inc;
        logic       rd_app;
        logic       emit;
        emit_kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        resp_kind_t kind;
        logic       n_zero;
        logic       cnt_last;
        logic       out_free;
    } status_t;

endpackage

@@ src/mtrs_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface mtrs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/mtrs_ctrl.sv @@
// Controller state machine of the register server.
module mtrs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_opcode,
    input  logic              req_frame_end,
    input  mtrs_pkg::status_t status,
    output logic              req_ready,
    output mtrs_pkg::cmd_t    cmd
);
    mtrs_pkg::state_t state_reg;
    mtrs_pkg::state_t state_next;
    logic             take;

    assign req_ready = (state_reg == mtrs_pkg::ST_IDLE);
    assign take      = req_ready & req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtrs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtrs_pkg::ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = mtrs_pkg::ST_IDLE;
                end
            end
            mtrs_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (req_opcode == mtrs_pkg::OP_REQ_BYTE && req_frame_end)
                    begin
                        state_next = mtrs_pkg::ST_DECODE;
                    end
                    else if (req_opcode == mtrs_pkg::OP_READ_HOLD)
                    begin
                        state_next = mtrs_pkg::ST_APP_RD;
                    end
                end
            end
            mtrs_pkg::ST_DECODE:
            begin
                unique case (status.kind)
                    mtrs_pkg::RK_NONE:   state_next = mtrs_pkg::ST_IDLE;
                    mtrs_pkg::RK_WRITEN:
                    begin
                        state_next = status.n_zero ? mtrs_pkg::ST_SINGLE
                                                   : mtrs_pkg::ST_COPY_RD;
                    end
                    mtrs_pkg::RK_READ:   state_next = mtrs_pkg::ST_READ_ADDR;
                    default:             state_next = mtrs_pkg::ST_SINGLE;
                endcase
            end
            mtrs_pkg::ST_APP_RD:
            begin
                state_next = mtrs_pkg::ST_APP_EMIT;
            end
            mtrs_pkg::ST_APP_EMIT, mtrs_pkg::ST_SINGLE:
            begin
                if (status.out_free)
                begin
                    state_next = mtrs_pkg::ST_IDLE;
                end
            end
            mtrs_pkg::ST_COPY_RD:
            begin
                state_next = mtrs_pkg::ST_COPY_WR;
            end
            mtrs_pkg::ST_COPY_WR:
            begin
                state_next = status.cnt_last ? mtrs_pkg::ST_SINGLE : mtrs_pkg::ST_COPY_RD;
            end
            mtrs_pkg::ST_READ_ADDR:
            begin
                state_next = mtrs_pkg::ST_READ_EMIT;
            end
            mtrs_pkg::ST_READ_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.cnt_last ? mtrs_pkg::ST_IDLE
                                                 : mtrs_pkg::ST_READ_ADDR;
                end
            end
            default:
            begin
                state_next = mtrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = mtrs_pkg::EK_SINGLE;
        cmd.take      = take;
        unique case (state_reg)
            mtrs_pkg::ST_CLEAR:     cmd.clr_step = 1'b1;
            mtrs_pkg::ST_DECODE:    cmd.hold_wr1 = (status.kind == mtrs_pkg::RK_WRITE1);
            mtrs_pkg::ST_APP_RD:    cmd.rd_app   = 1'b1;
            mtrs_pkg::ST_APP_EMIT:
            begin
                cmd.rd_app    = 1'b1;
                cmd.emit      = status.out_free;
                cmd.emit_kind = mtrs_pkg::EK_APP;
            end
            mtrs_pkg::ST_SINGLE:    cmd.emit = status.out_free;
            mtrs_pkg::ST_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            mtrs_pkg::ST_READ_EMIT:
            begin
                cmd.emit      = status.out_free;
                cmd.cnt_inc   = status.out_free;
                cmd.emit_kind = mtrs_pkg::EK_READ;
            end
            default:
            begin
            end
        endcase
    end
endmodule

@@ src/mtrs_datapath.sv @@
// Datapath: header capture, register memories, response formation and output register.
module mtrs_datapath #(
    parameter int REG_DEPTH = mtrs_pkg::REG_DEPTH_DEF,
    parameter int MAX_REGS  = mtrs_pkg::MAX_REGS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mtrs_pkg::cmd_t    cmd,
    input  mtrs_pkg::req_t    req_data,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output mtrs_pkg::rsp_t    rsp_data,
    output mtrs_pkg::status_t status
);
    localparam int AW    = $clog2(REG_DEPTH);
    localparam int WW_AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW    = $clog2(MAX_REGS + 1);

    logic [15:0] hold_mem [REG_DEPTH];
    logic [15:0] inp_mem  [REG_DEPTH];
    logic [15:0] ww_mem   [MAX_REGS];

    logic [7:0]    hb_reg [mtrs_pkg::HDR_LEN];
    logic [7:0]    pos_reg;
    logic [8:0]    len_reg;
    logic [7:0]    hi_reg;
    logic [7:0]    idx_reg;
    logic          app_ok_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] clr_reg;
    logic [15:0]   hold_rd_reg;
    logic [15:0]   inp_rd_reg;
    logic [15:0]   ww_rd_reg;
    logic          rsp_valid_reg;
    mtrs_pkg::rsp_t rsp_reg;
    mtrs_pkg::rsp_t rsp_next;

    logic [7:0]  g [mtrs_pkg::HDR_LEN];
    logic [7:0]  fc;
    logic [15:0] a_word;
    logic [15:0] n_word;
    logic [16:0] depth17;
    logic [16:0] end17;
    logic [16:0] sum17;
    logic [17:0] need16;
    logic        err_multi;
    mtrs_pkg::resp_kind_t kind;
    logic        take_byte;
    logic        take_load;
    logic        idx_ok;
    logic [7:0]  d_off;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] raddr;
    logic          hold_we;
    logic [AW-1:0] hold_waddr;
    logic [15:0]   hold_wdata;
    logic          inp_we;
    logic [AW-1:0] inp_waddr;
    logic [15:0]   inp_wdata;
    logic          ww_we;
    logic [7:0]    lenlo;
    logic [7:0]    n_x2;

    assign take_byte = cmd.take && (req_data.opcode == mtrs_pkg::OP_REQ_BYTE);
    assign take_load = cmd.take && (req_data.opcode == mtrs_pkg::OP_LOAD_INPUT);
    assign idx_ok    = (17'(req_data.reg_index) < 17'(REG_DEPTH));
    assign d_off     = pos_reg - 8'(mtrs_pkg::HDR_LEN);
    assign ww_we     = take_byte && (pos_reg >= 8'(mtrs_pkg::HDR_LEN)) && d_off[0]
                       && ({1'b0, d_off[7:1]} < 8'(MAX_REGS));

    // bytes not received in this frame read as zero
    always_comb
    begin
        for (int i = 0; i < mtrs_pkg::HDR_LEN; i++)
        begin
            g[i] = (9'(i) < len_reg) ? hb_reg[i] : 8'd0;
        end
    end

    assign fc      = g[7];
    assign a_word  = {g[8], g[9]};
    assign n_word  = {g[10], g[11]};
    assign depth17 = 17'(REG_DEPTH);
    assign end17   = 17'(a_word) + 17'(n_word);
    assign need16  = 18'(mtrs_pkg::HDR_LEN) + {1'b0, n_word, 1'b0};
    assign err_multi = (len_reg < 9'd12) || (17'(n_word) > 17'(MAX_REGS))
                       || (17'(a_word) >= depth17) || (end17 > depth17)
                       || ((fc == mtrs_pkg::FC_WR_MULTI) && (18'(len_reg) < need16));

    always_comb
    begin
        kind = mtrs_pkg::RK_NONE;
        if (len_reg < 9'd8)
        begin
            kind = mtrs_pkg::RK_NONE;
        end
        else if (fc == mtrs_pkg::FC_WR_SINGLE)
        begin
            kind = ((len_reg < 9'd12) || (17'(a_word) >= depth17)) ? mtrs_pkg::RK_ERROR
                                                                   : mtrs_pkg::RK_WRITE1;
        end
        else if (fc == mtrs_pkg::FC_RD_HOLD || fc == mtrs_pkg::FC_RD_INPUT
                 || fc == mtrs_pkg::FC_WR_MULTI)
        begin
            if (err_multi)
            begin
                kind = mtrs_pkg::RK_ERROR;
            end
            else if (fc == mtrs_pkg::FC_WR_MULTI)
            begin
                kind = mtrs_pkg::RK_WRITEN;
            end
            else if (n_word == 16'd0)
            begin
                kind = mtrs_pkg::RK_READ0;
            end
            else
            begin
                kind = mtrs_pkg::RK_READ;
            end
        end
    end

    assign sum17    = 17'(a_word) + 17'(cnt_reg);
    assign mem_addr = sum17[AW-1:0];
    assign raddr    = cmd.rd_app ? AW'(idx_reg) : mem_addr;

    assign hold_we    = cmd.clr_step | cmd.hold_wr1 | cmd.copy_wr;
    assign hold_waddr = cmd.clr_step ? clr_reg : mem_addr;
    assign hold_wdata = cmd.clr_step ? 16'd0 : (cmd.hold_wr1 ? n_word : ww_rd_reg);
    assign inp_we     = cmd.clr_step | (take_load & idx_ok);
    assign inp_waddr  = cmd.clr_step ? clr_reg : AW'(req_data.reg_index);
    assign inp_wdata  = cmd.clr_step ? 16'd0 : req_data.reg_value;

    always_ff @(posedge clk)
    begin
        if (hold_we)
        begin
            hold_mem[hold_waddr] <= hold_wdata;
        end
        hold_rd_reg <= hold_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (inp_we)
        begin
            inp_mem[inp_waddr] <= inp_wdata;
        end
        inp_rd_reg <= inp_mem[raddr];
    end

    // data bytes after the header pair up into words; high byte waits in hi_reg
    always_ff @(posedge clk)
    begin
        if (ww_we)
        begin
            ww_mem[d_off[WW_AW:1]] <= {hi_reg, req_data.data_byte};
        end
        ww_rd_reg <= ww_mem[cnt_reg[WW_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            if (pos_reg < 8'(mtrs_pkg::HDR_LEN))
            begin
                hb_reg[pos_reg[3:0]] <= req_data.data_byte;
            end
            else if (!d_off[0])
            begin
                hi_reg <= req_data.data_byte;
            end
        end
        if (cmd.take)
        begin
            idx_reg    <= req_data.reg_index;
            app_ok_reg <= idx_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_byte)
            begin
                if (req_data.frame_end)
                begin
                    pos_reg <= '0;
                    len_reg <= 9'(pos_reg) + 9'd1;
                end
                else if (pos_reg != 8'hFF)
                begin
                    pos_reg <= pos_reg + 8'd1;
                end
            end
            if (cmd.take)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign n_x2 = {n_word[6:0], 1'b0};

    always_comb
    begin
        rsp_next = '0;
        lenlo    = 8'd0;
        case (cmd.emit_kind)
            mtrs_pkg::EK_APP:
            begin
                rsp_next.word_a   = app_ok_reg ? hold_rd_reg : 16'd0;
                rsp_next.has_data = 1'b1;
                rsp_next.last     = 1'b1;
            end
            mtrs_pkg::EK_SINGLE:
            begin
                rsp_next.last = 1'b1;
                case (kind)
                    mtrs_pkg::RK_ERROR:
                    begin
                        rsp_next.word_a = a_word;
                        rsp_next.word_b = n_word;
                        rsp_next.error  = 1'b1;
                    end
                    mtrs_pkg::RK_WRITE1:
                    begin
                        lenlo           = 8'd6;
                        rsp_next.word_a = a_word;
                        rsp_next.word_b = n_word;
                    end
                    mtrs_pkg::RK_WRITEN:
                    begin
                        lenlo               = 8'd6;
                        rsp_next.byte_count = g[12];
                        rsp_next.word_a     = a_word;
                        rsp_next.word_b     = n_word;
                    end
                    default:
                    begin
                        lenlo = 8'd3;
                    end
                endcase
            end
            mtrs_pkg::EK_READ:
            begin
                lenlo               = n_x2 + 8'd3;
                rsp_next.byte_count = n_x2;
                rsp_next.word_a     = (fc == mtrs_pkg::FC_RD_HOLD) ? hold_rd_reg : inp_rd_reg;
                rsp_next.has_data   = 1'b1;
                rsp_next.last       = status.cnt_last;
            end
            default:
            begin
            end
        endcase
        if (cmd.emit_kind != mtrs_pkg::EK_APP)
        begin
            rsp_next.transaction_id = {g[0], g[1]};
            rsp_next.protocol_id    = {g[2], g[3]};
            rsp_next.length_field   = {g[4], lenlo};
            rsp_next.unit_id        = g[6];
            rsp_next.function_code  = fc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign status.clr_done = (clr_reg == AW'(REG_DEPTH - 1));
    assign status.kind     = kind;
    assign status.n_zero   = (n_word == 16'd0);
    assign status.cnt_last = ((17'(cnt_reg) + 17'd1) == 17'(n_word));
    assign status.out_free = !rsp_valid_reg || rsp_ready;
endmodule

@@ src/modbus_tcp_register_server.sv @@
// Top level of the Modbus TCP register server.
// Accepts one request byte, input-register load or holding-register read per transaction.
// Request bytes and loads are taken in the idle state; after reset a clearing pass zeroes
// every address of both register memories before the first transaction is taken. On the
// frame-end byte the request is decoded, then: codes 3/4 give one response transaction per
// register, each via an address state and an emit state on the registered memory read
// port; code 16 copies its data words into the holding memory via a read state and a write
// state per word before its single response; code 6 and error responses follow decode in
// the single-response state. An application read of a holding register passes a read and
// an emit state. Output stalls hold the controller in its emit state and block further input.
module modbus_tcp_register_server #(
    parameter int REG_DEPTH = mtrs_pkg::REG_DEPTH_DEF,
    parameter int MAX_REGS  = mtrs_pkg::MAX_REGS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mtrs_stream_if.sink   req,
    mtrs_stream_if.source rsp
);
    mtrs_pkg::cmd_t    cmd;
    mtrs_pkg::status_t status;
    mtrs_pkg::req_t    req_data;
    mtrs_pkg::rsp_t    rsp_data;
    logic              req_ready;
    logic              rsp_valid;

    assign req_data    = req.payload;
    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_data;

    mtrs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_opcode    (req_data.opcode),
        .req_frame_end (req_data.frame_end),
        .status        (status),
        .req_ready     (req_ready),
        .cmd           (cmd)
    );

    mtrs_datapath #(
        .REG_DEPTH (REG_DEPTH),
        .MAX_REGS  (MAX_REGS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_data  (req_data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .status    (status)
    );
endmodule

@@ src/mtrs_checker.sv @@
// Port-level checks of the register server, bound to the top level.
module mtrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] word_a,
    input logic [15:0] length_field,
    input logic [7:0]  function_code,
    input logic [7:0]  byte_count,
    input logic        has_data,
    input logic        last,
    input logic        error
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(word_a))
        else $error("response data changed while stalled");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error |-> last && !has_data)
        else $error("error response not a single final transaction");

    a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && has_data && function_code != 8'd0
        |-> length_field[7:0] == byte_count + 8'd3)
        else $error("read length field disagrees with byte count");
endmodule

bind modbus_tcp_register_server mtrs_checker u_mtrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .word_a        (rsp.payload.word_a),
    .length_field  (rsp.payload.length_field),
    .function_code (rsp.payload.function_code),
    .byte_count    (rsp.payload.byte_count),
    .has_data      (rsp.payload.has_data),
    .last          (rsp.payload.last),
    .error         (rsp.payload.error)
);
